### rtl/skm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types and constants for the serial keyword matcher: register
// indexes, default keywords and field widths.
// ----------------------------------------------------------------------------
package skm_pkg;

    // Longest keyword the matcher can hold
    localparam int SKM_MAX_KEYWORD_LEN = 8;

    // Field widths
    localparam int SKM_BYTE_W    = 8;
    localparam int SKM_KEYWORD_W = 64;
    localparam int SKM_LEN_W     = 4;

    typedef logic [SKM_BYTE_W-1:0]    t_byte;
    typedef logic [SKM_KEYWORD_W-1:0] t_keyword;
    typedef logic [SKM_LEN_W-1:0]     t_len;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEYWORD_A = 2'd0,
        CFG_KEYWORD_B = 2'd1,
        CFG_LENGTH_A  = 2'd2,
        CFG_LENGTH_B  = 2'd3
    } t_cfg_index;

    // Default keywords, first character in the lowest byte
    localparam t_keyword SKM_KEYWORD_A_RST = 64'h4554_4952_572B_5441; // AT+WRITE
    localparam t_keyword SKM_KEYWORD_B_RST = 64'h0044_4145_522B_5441; // AT+READ
    localparam t_len     SKM_LENGTH_A_RST  = 4'd8;
    localparam t_len     SKM_LENGTH_B_RST  = 4'd7;

endpackage : skm_pkg
`default_nettype wire

### rtl/serial_keyword_matcher.sv
`default_nettype none
// A result appears on the output register in the cycle after the
// transfer of the byte that completes a keyword.
// Throughput: one byte per cycle while a shown result is not stalled; the comparison
// against both keywords is a single pass of byte compares between the input port and the result register.
// Reset: synchronous, active low; returns to waiting for a first character
// and restores the default keywords AT+WRITE and AT+READ.
// ----------------------------------------------------------------------------
// serial_keyword_matcher
// Watches a received byte stream for two configurable keywords and reports
// the index of the keyword that was fully matched.
// ----------------------------------------------------------------------------
module serial_keyword_matcher #(
    parameter int MAX_KEYWORD_LEN = skm_pkg::SKM_MAX_KEYWORD_LEN
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // configuration write channel
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire skm_pkg::t_cfg_index  i_cfg_index,
    input  wire skm_pkg::t_keyword    i_cfg_data,
    // received byte channel
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire skm_pkg::t_byte       i_rx_byte,
    // match result channel
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic                      o_matched_keyword
);
    import skm_pkg::*;

    localparam int PW = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int IW = $clog2(MAX_KEYWORD_LEN);

    typedef logic [PW-1:0] t_pos;
    typedef logic [MAX_KEYWORD_LEN-1:0][SKM_BYTE_W-1:0] t_kw_bytes;

    // Clamp a programmed length into 1..MAX_KEYWORD_LEN
    function automatic t_pos eff_len(input t_len len);
        t_pos l;
        if (len == '0) begin
            l = t_pos'(1);
        end else if (len > SKM_LEN_W'(MAX_KEYWORD_LEN)) begin
            l = t_pos'(MAX_KEYWORD_LEN);
        end else begin
            l = t_pos'(len);
        end
        return l;
    endfunction

    // Configuration registers
    t_keyword r_keyword_a;
    t_keyword r_keyword_b;
    t_len     r_length_a;
    t_len     r_length_b;

    // Match state
    logic       r_selecting;
    t_pos       r_pos;
    logic [1:0] r_mask;

    // Result register
    logic r_out_valid;
    logic r_matched;

    logic       w_in_fire;
    t_pos       w_pos;
    logic [1:0] w_prior;
    t_kw_bytes  w_bytes_a;
    t_kw_bytes  w_bytes_b;
    t_pos       w_len_a;
    t_pos       w_len_b;
    logic [1:0] w_hit;
    logic       w_single;
    logic       w_idx;
    logic       w_done;
    t_pos       n_pos;

    assign o_cfg_ready       = 1'b1;
    assign o_in_ready        = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_matched_keyword = r_matched;
    assign w_in_fire         = i_in_valid && o_in_ready;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyword_a <= SKM_KEYWORD_A_RST;
            r_keyword_b <= SKM_KEYWORD_B_RST;
            r_length_a  <= SKM_LENGTH_A_RST;
            r_length_b  <= SKM_LENGTH_B_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEYWORD_A: r_keyword_a <= i_cfg_data;
                CFG_KEYWORD_B: r_keyword_b <= i_cfg_data;
                CFG_LENGTH_A:  r_length_a  <= i_cfg_data[SKM_LEN_W-1:0];
                CFG_LENGTH_B:  r_length_b  <= i_cfg_data[SKM_LEN_W-1:0];
                default:       r_length_b  <= r_length_b;
            endcase
        end
    end

    // Compare the incoming byte against both keywords at the current position
    always_comb begin
        w_pos     = r_selecting ? r_pos : '0;
        w_prior   = r_selecting ? r_mask : 2'b11;
        w_bytes_a = r_keyword_a[SKM_BYTE_W*MAX_KEYWORD_LEN-1:0];
        w_bytes_b = r_keyword_b[SKM_BYTE_W*MAX_KEYWORD_LEN-1:0];
        w_len_a   = eff_len(r_length_a);
        w_len_b   = eff_len(r_length_b);
        w_hit[0]  = w_prior[0] && (w_pos < w_len_a)
                    && (w_bytes_a[w_pos[IW-1:0]] == i_rx_byte);
        w_hit[1]  = w_prior[1] && (w_pos < w_len_b)
                    && (w_bytes_b[w_pos[IW-1:0]] == i_rx_byte);
        w_single  = w_hit[0] ^ w_hit[1];
        w_idx     = w_hit[1];
        w_done    = w_single
                    && ((w_pos + t_pos'(1)) == (w_idx ? w_len_b : w_len_a));
        n_pos     = (w_pos < t_pos'(MAX_KEYWORD_LEN)) ? w_pos + t_pos'(1)
                                                      : t_pos'(MAX_KEYWORD_LEN);
    end

    // Advance the match state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selecting <= 1'b0;
            r_pos       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                if ((w_hit == 2'b00) || w_done) begin
                    r_selecting <= 1'b0;
                    r_pos       <= '0;
                    r_mask      <= '0;
                end else begin
                    r_selecting <= 1'b1;
                    r_pos       <= n_pos;
                    r_mask      <= w_hit;
                end
                r_out_valid <= w_done;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_done) begin
            r_matched <= w_idx;
        end
    end

    // Waiting for a first character leaves no position and no candidates
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_selecting |-> (r_pos == '0) && (r_mask == 2'b00))
        else $error("idle state holds a position or candidates");

    // Selecting always keeps at least one candidate and a non-zero position
    a_sel_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_selecting |-> (r_mask != 2'b00) && (r_pos != '0))
        else $error("selecting without candidates or position");

    // A completed keyword shows a result and returns to idle
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_done) |=> (o_out_valid && !r_selecting
                                   && (o_matched_keyword == $past(w_idx))))
        else $error("completed keyword did not produce a result");

    // A transfer that completes nothing leaves the result register empty
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_done) |=> !o_out_valid)
        else $error("result shown without a completed keyword");

endmodule : serial_keyword_matcher
`default_nettype wire
